@@ hdl/ecs_pkg.sv @@
package ecs_pkg;

  localparam int SAMPLE_W = 10;
  localparam int THR_SHIFT = 3;
  localparam int THR_W = SAMPLE_W - THR_SHIFT;
  localparam int SUM_W = SAMPLE_W + 1;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

  // input item layout: base_tick, slow_tick, light_a, light_b, threshold_raw
  localparam int IN_BITS = 2 + 3 * SAMPLE_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int LIGHT_A_LSB = 2;
  localparam int LIGHT_B_LSB = LIGHT_A_LSB + SAMPLE_W;
  localparam int THR_LSB = LIGHT_B_LSB + SAMPLE_W;

  localparam int CODE_W = 3;
  localparam int CNT_W = 8;
  localparam int LIM_W = CNT_W + 1;

  localparam logic [1:0] PH_REFRACTORY = 2'd0;
  localparam logic [1:0] PH_EXCITABLE  = 2'd1;
  localparam logic [1:0] PH_ACTIVATING = 2'd2;
  localparam logic [1:0] PH_EXCITED    = 2'd3;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY_CODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_CODE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXCITED_CODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SELF_COUNT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SELF_ENABLE     = 3'd4;

  typedef struct packed {
    logic [CODE_W-1:0] refractory_code;
    logic [CODE_W-1:0] delay_code;
    logic [CODE_W-1:0] excited_code;
    logic [CNT_W-1:0]  self_trigger_count;
    logic              self_trigger_enable;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic preset;
  } lane_ctl_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       fired;
  } result_t;

endpackage

@@ hdl/excitable_cell_sequencer.sv @@
// Four-phase excitable cell (refractory, excitable, activating, excited). Each input item is
// handled in the cycle it is accepted; one result item per input item enters the output
// register. One item is taken every cycle unless the skid is full. Two compare lanes, one per
// light channel, test the rise against their stored previous sample in parallel and the phase
// sequencer merges their hits with the slow-tick self trigger. A two-entry output buffer keeps
// input accepted while one result is stalled. Configuration writes are always accepted.
module excitable_cell_sequencer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // base_tick, slow_tick, light_a, light_b, threshold_raw
  input  logic [ecs_pkg::IN_DATA_W-1:0]    in_tdata,
  // sample_valid
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // excited_led, excitable_led, phase, fired, zero pad
  output logic [7:0]                       out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ecs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ecs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  ecs_pkg::cfg_t      cfg_r;
  ecs_pkg::lane_ctl_t lane_ctl;
  ecs_pkg::result_t   res;
  logic [1:0]         cur_phase;
  logic               in_acc, out_pop;
  logic               hit_a, hit_b;
  logic [ecs_pkg::SAMPLE_W-1:0] light_a, light_b, threshold_raw;
  logic [7:0]         res_data;
  logic               out_v_r, skid_v_r;
  logic [7:0]         out_d_r, skid_d_r;

  assign light_a       = in_tdata[ecs_pkg::LIGHT_A_LSB +: ecs_pkg::SAMPLE_W];
  assign light_b       = in_tdata[ecs_pkg::LIGHT_B_LSB +: ecs_pkg::SAMPLE_W];
  assign threshold_raw = in_tdata[ecs_pkg::THR_LSB +: ecs_pkg::SAMPLE_W];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.refractory_code     <= 3'd6;
      cfg_r.delay_code          <= 3'd4;
      cfg_r.excited_code        <= 3'd3;
      cfg_r.self_trigger_count  <= 8'd32;
      cfg_r.self_trigger_enable <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ecs_pkg::REG_REFRACTORY_CODE: cfg_r.refractory_code <= cfg_data[ecs_pkg::CODE_W-1:0];
        ecs_pkg::REG_DELAY_CODE:      cfg_r.delay_code <= cfg_data[ecs_pkg::CODE_W-1:0];
        ecs_pkg::REG_EXCITED_CODE:    cfg_r.excited_code <= cfg_data[ecs_pkg::CODE_W-1:0];
        ecs_pkg::REG_SELF_COUNT:      cfg_r.self_trigger_count <= cfg_data;
        ecs_pkg::REG_SELF_ENABLE:     cfg_r.self_trigger_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_tready = !skid_v_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_pop   = out_v_r && out_tready;

  ecs_lane u_lane_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (lane_ctl),
    .sample (light_a),
    .thr    (threshold_raw[ecs_pkg::SAMPLE_W-1:ecs_pkg::THR_SHIFT]),
    .hit    (hit_a)
  );

  ecs_lane u_lane_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (lane_ctl),
    .sample (light_b),
    .thr    (threshold_raw[ecs_pkg::SAMPLE_W-1:ecs_pkg::THR_SHIFT]),
    .hit    (hit_b)
  );

  ecs_phase u_phase (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .acc          (in_acc),
    .base_tick    (in_tdata[0]),
    .slow_tick    (in_tdata[1]),
    .sample_valid (in_tuser),
    .hit_a        (hit_a),
    .hit_b        (hit_b),
    .lane_ctl     (lane_ctl),
    .res          (res),
    .cur_phase    (cur_phase)
  );

  assign res_data = {3'b000, res.fired, res.phase,
                     res.phase == ecs_pkg::PH_EXCITABLE,
                     res.phase == ecs_pkg::PH_EXCITED};

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_v_r && !out_pop) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_pop) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_pop) begin
        out_d_r <= skid_d_r;
      end
    end else if (in_acc) begin
      if (out_v_r && !out_pop) begin
        skid_d_r <= res_data;
      end else begin
        out_d_r <= res_data;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held without output entry");

  a_phase_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(cur_phase))
    else $error("phase moved without an item");

  a_fire_to_activating: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res.fired) |=> (cur_phase == ecs_pkg::PH_ACTIVATING))
    else $error("trigger did not enter activating phase");

  a_fire_only_excitable: assert property (@(posedge clk) disable iff (!rst_n)
    res.fired |-> (cur_phase == ecs_pkg::PH_EXCITABLE && in_acc))
    else $error("trigger outside excitable phase");

endmodule

@@ hdl/ecs_lane.sv @@
module ecs_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ecs_pkg::lane_ctl_t            ctl,
  input  logic [ecs_pkg::SAMPLE_W-1:0]  sample,
  input  logic [ecs_pkg::THR_W-1:0]     thr,
  output logic                          hit
);

  logic [ecs_pkg::SAMPLE_W-1:0] prev_r;
  logic [ecs_pkg::SUM_W-1:0]    need;

  // rise test against the previous sample of this channel
  assign need = {1'b0, prev_r} + ecs_pkg::SUM_W'(thr);
  assign hit  = {1'b0, sample} >= need;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= ecs_pkg::SAMPLE_MAX;
    end else if (ctl.preset) begin
      prev_r <= ecs_pkg::SAMPLE_MAX;
    end else if (ctl.load) begin
      prev_r <= sample;
    end
  end

endmodule

@@ hdl/ecs_phase.sv @@
module ecs_phase (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ecs_pkg::cfg_t              cfg,
  input  logic                       acc,
  input  logic                       base_tick,
  input  logic                       slow_tick,
  input  logic                       sample_valid,
  input  logic                       hit_a,
  input  logic                       hit_b,
  output ecs_pkg::lane_ctl_t         lane_ctl,
  output ecs_pkg::result_t           res,
  output logic [1:0]                 cur_phase
);

  logic [1:0]                phase_r, phase_nxt;
  logic [ecs_pkg::CNT_W-1:0] tick_r, tick_nxt;
  logic [ecs_pkg::CNT_W-1:0] slow_r, slow_nxt;
  logic                      self_r, self_nxt;
  logic [ecs_pkg::CODE_W-1:0] code;
  logic [ecs_pkg::LIM_W-1:0] limit;
  logic [ecs_pkg::LIM_W-1:0] tick_inc;
  logic [ecs_pkg::CNT_W-1:0] slow_inc;
  logic                      trig;
  logic                      fired;

  assign cur_phase = phase_r;

  always_comb begin
    unique case (phase_r)
      ecs_pkg::PH_REFRACTORY: code = cfg.refractory_code;
      ecs_pkg::PH_ACTIVATING: code = cfg.delay_code;
      default:                code = cfg.excited_code;
    endcase
  end

  assign limit    = ecs_pkg::LIM_W'(1) << code;
  assign tick_inc = {1'b0, tick_r} + ecs_pkg::LIM_W'(1);
  assign slow_inc = slow_r + ecs_pkg::CNT_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    slow_nxt  = slow_r;
    self_nxt  = self_r;
    trig      = 1'b0;
    fired     = 1'b0;
    lane_ctl  = '0;
    if (acc) begin
      if (phase_r == ecs_pkg::PH_EXCITABLE) begin
        if (slow_tick) begin
          slow_nxt = slow_inc;
          if (slow_inc == cfg.self_trigger_count && cfg.self_trigger_enable) begin
            self_nxt = 1'b1;
          end
        end
        // merge the lane results with the forced trigger
        trig = self_nxt || (sample_valid && (hit_a || hit_b));
        lane_ctl.load = sample_valid;
        if (trig) begin
          fired     = 1'b1;
          phase_nxt = ecs_pkg::PH_ACTIVATING;
          tick_nxt  = '0;
        end
      end else if (base_tick) begin
        tick_nxt = tick_inc[ecs_pkg::CNT_W-1:0];
        if (tick_inc >= limit) begin
          phase_nxt = phase_r + 2'd1;
          tick_nxt  = '0;
          if (phase_nxt == ecs_pkg::PH_EXCITABLE) begin
            lane_ctl.preset = 1'b1;
            slow_nxt        = '0;
            self_nxt        = 1'b0;
          end
        end
      end
    end
  end

  assign res.phase = phase_nxt;
  assign res.fired = fired;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ecs_pkg::PH_REFRACTORY;
      tick_r  <= '0;
      slow_r  <= '0;
      self_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      slow_r  <= slow_nxt;
      self_r  <= self_nxt;
    end
  end

endmodule

@@ dv/tb_excitable_cell_sequencer.sv @@
`timescale 1ns / 1ps

module tb_excitable_cell_sequencer;

  localparam logic [ecs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic       base_tick;
    logic       slow_tick;
    logic       fresh;
    logic [9:0] light_a;
    logic [9:0] light_b;
    logic [9:0] thr_raw;
  } cell_item_t;

  typedef struct {
    logic       excited_led;
    logic       excitable_led;
    logic [1:0] phase;
    logic       fired;
  } cell_res_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [31:0]                    in_tdata = '0;
  logic                           in_tuser = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [7:0]                     out_tdata;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [ecs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ecs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  excitable_cell_sequencer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  ecs_pkg::cfg_t cell_cfg;
  logic [1:0]    cell_phase;
  logic [7:0]    tick_cnt;
  logic [9:0]    prev_a;
  logic [9:0]    prev_b;
  logic [7:0]    slow_cnt;
  logic          self_arm;

  cell_item_t pend_q[$];
  cell_res_t  cell_res_q[$];
  int         mismatch_cnt = 0;
  int         accepted_cnt = 0;
  bit         in_taken = 1'b0;
  int         gap_left = 0;
  int         burst_left = 0;
  int         rx_cycle = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;

  function automatic void enter_cell_phase(input logic [1:0] p);
    cell_phase = p;
    tick_cnt = 8'd0;
    if (p == ecs_pkg::PH_EXCITABLE) begin
      prev_a = ecs_pkg::SAMPLE_MAX;
      prev_b = ecs_pkg::SAMPLE_MAX;
      slow_cnt = 8'd0;
      self_arm = 1'b0;
    end
  endfunction

  function automatic cell_res_t advance_cell(input cell_item_t it);
    cell_res_t  r;
    logic       fire;
    logic [2:0] code;
    logic [8:0] span;
    fire = 1'b0;
    if (cell_phase == ecs_pkg::PH_EXCITABLE) begin
      if (it.slow_tick) begin
        slow_cnt = slow_cnt + 8'd1;
        if (slow_cnt == cell_cfg.self_trigger_count && cell_cfg.self_trigger_enable)
          self_arm = 1'b1;
      end
      if (self_arm)
        fire = 1'b1;
      if (it.fresh) begin
        if ({1'b0, it.light_a} >= {1'b0, prev_a} + {4'd0, it.thr_raw[9:3]})
          fire = 1'b1;
        if ({1'b0, it.light_b} >= {1'b0, prev_b} + {4'd0, it.thr_raw[9:3]})
          fire = 1'b1;
        prev_a = it.light_a;
        prev_b = it.light_b;
      end
      if (fire)
        enter_cell_phase(ecs_pkg::PH_ACTIVATING);
    end else if (it.base_tick) begin
      case (cell_phase)
        ecs_pkg::PH_REFRACTORY: code = cell_cfg.refractory_code;
        ecs_pkg::PH_ACTIVATING: code = cell_cfg.delay_code;
        default:                code = cell_cfg.excited_code;
      endcase
      span = 9'd1 << code;
      tick_cnt = tick_cnt + 8'd1;
      if ({1'b0, tick_cnt} >= span)
        enter_cell_phase(cell_phase + 2'd1);
    end
    r.excited_led = (cell_phase == ecs_pkg::PH_EXCITED);
    r.excitable_led = (cell_phase == ecs_pkg::PH_EXCITABLE);
    r.phase = cell_phase;
    r.fired = fire;
    return r;
  endfunction

  // input acceptance and result checking
  always @(posedge clk) begin
    cell_item_t it;
    cell_res_t  got;
    cell_res_t  want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.excited_led = out_tdata[0];
        got.excitable_led = out_tdata[1];
        got.phase = out_tdata[3:2];
        got.fired = out_tdata[4];
        if (cell_res_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result item, expected none, actual %h", $time, out_tdata);
        end else begin
          want = cell_res_q.pop_front();
          if (got.excited_led !== want.excited_led) begin
            mismatch_cnt++;
            $display("%0t: excited_led expected %0d actual %0d", $time,
                     want.excited_led, got.excited_led);
          end
          if (got.excitable_led !== want.excitable_led) begin
            mismatch_cnt++;
            $display("%0t: excitable_led expected %0d actual %0d", $time,
                     want.excitable_led, got.excitable_led);
          end
          if (got.phase !== want.phase) begin
            mismatch_cnt++;
            $display("%0t: phase expected %0d actual %0d", $time, want.phase, got.phase);
          end
          if (got.fired !== want.fired) begin
            mismatch_cnt++;
            $display("%0t: fired expected %0d actual %0d", $time, want.fired, got.fired);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        it.base_tick = in_tdata[0];
        it.slow_tick = in_tdata[1];
        it.light_a = in_tdata[11:2];
        it.light_b = in_tdata[21:12];
        it.thr_raw = in_tdata[31:22];
        it.fresh = in_tuser;
        cell_res_q.push_back(advance_cell(it));
        accepted_cnt++;
        in_taken = 1'b1;
      end
    end
  end

  // sender: bursts with random gaps
  always @(negedge clk) begin
    cell_item_t nxt;
    if (!in_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        nxt = pend_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {nxt.thr_raw, nxt.light_b, nxt.light_a, nxt.slow_tick, nxt.base_tick};
        in_tuser <= nxt.fresh;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern plus one long hold-off
  always @(negedge clk) begin
    rx_cycle++;
    if (!hold_done && accepted_cnt >= 400) begin
      hold_done = 1'b1;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case ((rx_cycle / 64) % 4)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  function automatic cell_item_t make_item(input logic bt, input logic st, input logic fr,
                                           input logic [9:0] a, input logic [9:0] b,
                                           input logic [9:0] thr);
    cell_item_t it;
    it.base_tick = bt;
    it.slow_tick = st;
    it.fresh = fr;
    it.light_a = a;
    it.light_b = b;
    it.thr_raw = thr;
    return it;
  endfunction

  function automatic cell_item_t rand_item(input int base_pct, input int slow_pct,
                                           input int fresh_pct);
    logic [9:0] thr;
    thr = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 1023))
                                      : 10'($urandom_range(0, 63));
    return make_item($urandom_range(0, 99) < base_pct, $urandom_range(0, 99) < slow_pct,
                     $urandom_range(0, 99) < fresh_pct, 10'($urandom_range(0, 1023)),
                     10'($urandom_range(0, 1023)), thr);
  endfunction

  task automatic wait_idle();
    while (pend_q.size() != 0 || in_tvalid || cell_res_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ecs_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ecs_pkg::REG_REFRACTORY_CODE: cell_cfg.refractory_code = val[2:0];
      ecs_pkg::REG_DELAY_CODE:      cell_cfg.delay_code = val[2:0];
      ecs_pkg::REG_EXCITED_CODE:    cell_cfg.excited_code = val[2:0];
      ecs_pkg::REG_SELF_COUNT:      cell_cfg.self_trigger_count = val;
      ecs_pkg::REG_SELF_ENABLE:     cell_cfg.self_trigger_enable = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [2:0] rc, input logic [2:0] dc, input logic [2:0] ec,
                            input logic [7:0] cnt, input logic en);
    wait_idle();
    write_reg(ecs_pkg::REG_REFRACTORY_CODE, {5'd0, rc});
    write_reg(ecs_pkg::REG_DELAY_CODE, {5'd0, dc});
    write_reg(ecs_pkg::REG_EXCITED_CODE, {5'd0, ec});
    write_reg(ecs_pkg::REG_SELF_COUNT, cnt);
    write_reg(ecs_pkg::REG_SELF_ENABLE, {7'd0, en});
  endtask

  initial begin
    cell_cfg.refractory_code = 3'd6;
    cell_cfg.delay_code = 3'd4;
    cell_cfg.excited_code = 3'd3;
    cell_cfg.self_trigger_count = 8'd32;
    cell_cfg.self_trigger_enable = 1'b0;
    cell_phase = ecs_pkg::PH_REFRACTORY;
    tick_cnt = 8'd0;
    prev_a = ecs_pkg::SAMPLE_MAX;
    prev_b = ecs_pkg::SAMPLE_MAX;
    slow_cnt = 8'd0;
    self_arm = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings
    repeat (100) pend_q.push_back(rand_item(80, 40, 50));

    // directed: short phases, self trigger after two slow ticks
    set_config(3'd0, 3'd0, 3'd0, 8'd2, 1'b1);
    write_reg(REG_UNUSED, 8'hFF);
    pend_q.push_back(make_item(1, 0, 0, 0, 0, 0));
    pend_q.push_back(make_item(0, 0, 1, 1023, 0, 0));
    repeat (3) pend_q.push_back(make_item(1, 0, 0, 0, 0, 0));
    pend_q.push_back(make_item(0, 0, 1, 0, 1023, 7));
    repeat (3) pend_q.push_back(make_item(1, 0, 0, 0, 0, 0));
    pend_q.push_back(make_item(0, 0, 1, 100, 100, 1023));
    pend_q.push_back(make_item(0, 0, 1, 227, 0, 1023));
    repeat (3) pend_q.push_back(make_item(1, 0, 0, 0, 0, 0));
    pend_q.push_back(make_item(0, 1, 0, 0, 0, 0));
    pend_q.push_back(make_item(1, 1, 0, 0, 0, 0));
    pend_q.push_back(make_item(0, 1, 1, 1023, 1023, 0));
    repeat (3) pend_q.push_back(make_item(1, 0, 0, 0, 0, 0));
    pend_q.push_back(make_item(0, 1, 1, 0, 0, 1023));
    pend_q.push_back(make_item(1, 1, 1, 1023, 1023, 1023));

    // longest phases, widest count, self trigger off
    set_config(3'd7, 3'd7, 3'd7, 8'd255, 1'b0);
    repeat (150) pend_q.push_back(rand_item(90, 50, 50));

    // zero count wraps: forced trigger after 256 slow ticks
    set_config(3'd0, 3'd0, 3'd0, 8'd0, 1'b1);
    repeat (300) pend_q.push_back(make_item(1, 1, 0, 10'($urandom_range(0, 1023)),
                                            10'($urandom_range(0, 1023)),
                                            10'($urandom_range(0, 1023))));

    repeat (5) begin
      set_config(3'($urandom_range(0, 3)), 3'($urandom_range(0, 3)), 3'($urandom_range(0, 3)),
                 8'($urandom_range(1, 8)), 1'($urandom_range(0, 1)));
      repeat (40) pend_q.push_back(rand_item(60, 50, 50));
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/ecs_pkg.sv
hdl/ecs_lane.sv
hdl/ecs_phase.sv
hdl/excitable_cell_sequencer.sv
dv/tb_excitable_cell_sequencer.sv
